FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros used by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property checked on every clock edge outside reset
`define FTC_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("field type classifier check failed");

// condition that must never be true outside reset
`define FTC_ASSERT_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("field type classifier forbidden condition");

`else

`define FTC_ASSERT(label, prop)
`define FTC_ASSERT_NEVER(label, expr)

`endif

`endif

FILE: hdl/ftc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftc_pkg
// types, character codes and word tables for the field type classifier
// ----------------------------------------------------------------------------
package ftc_pkg;

	typedef enum logic [9:0] {
		ST_START   = 10'b00_0000_0001,
		ST_SIGN    = 10'b00_0000_0010,
		ST_INT     = 10'b00_0000_0100,
		ST_POINT   = 10'b00_0000_1000,
		ST_FRAC    = 10'b00_0001_0000,
		ST_EXPE    = 10'b00_0010_0000,
		ST_EXPSIGN = 10'b00_0100_0000,
		ST_EXP     = 10'b00_1000_0000,
		ST_WORD    = 10'b01_0000_0000,
		ST_STR     = 10'b10_0000_0000
	} lex_state_t;

	typedef enum logic [2:0] {
		TYPE_EMPTY = 3'd0,
		TYPE_UINT  = 3'd1,
		TYPE_SINT  = 3'd2,
		TYPE_FLOAT = 3'd3,
		TYPE_BOOL  = 3'd4,
		TYPE_STR   = 3'd5
	} field_type_t;

	typedef struct packed {
		lex_state_t  state;
		logic        saw_sign;
		logic        saw_digit;
		logic [2:0]  pos;
		logic        is_false;
	} lex_t;

	localparam lex_t LEX_RESET = '{
		state:     ST_START,
		saw_sign:  1'b0,
		saw_digit: 1'b0,
		pos:       3'd0,
		is_false:  1'b0
	};

	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_POINT  = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UP_E   = 8'h45;
	localparam logic [7:0] CH_UP_F   = 8'h46;
	localparam logic [7:0] CH_UP_T   = 8'h54;
	localparam logic [7:0] CH_LOW_A  = 8'h61;
	localparam logic [7:0] CH_LOW_E  = 8'h65;
	localparam logic [7:0] CH_LOW_L  = 8'h6C;
	localparam logic [7:0] CH_LOW_R  = 8'h72;
	localparam logic [7:0] CH_LOW_S  = 8'h73;
	localparam logic [7:0] CH_LOW_U  = 8'h75;

	localparam logic [2:0] LEN_TRUE  = 3'd4;
	localparam logic [2:0] LEN_FALSE = 3'd5;

	function automatic logic is_dig(logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_sgn(logic [7:0] c);
		return (c == CH_PLUS) || (c == CH_MINUS);
	endfunction

	function automatic logic is_exp(logic [7:0] c);
		return (c == CH_LOW_E) || (c == CH_UP_E);
	endfunction

	function automatic logic [2:0] word_len(logic is_false);
		return is_false ? LEN_FALSE : LEN_TRUE;
	endfunction

	// expected character at a position of True or False
	function automatic logic [7:0] word_char(logic is_false, logic [2:0] pos);
		logic [7:0] c;
		c = 8'h00;
		if (is_false) begin
			unique case (pos)
				3'd0:    c = CH_UP_F;
				3'd1:    c = CH_LOW_A;
				3'd2:    c = CH_LOW_L;
				3'd3:    c = CH_LOW_S;
				3'd4:    c = CH_LOW_E;
				default: c = 8'h00;
			endcase
		end else begin
			unique case (pos)
				3'd0:    c = CH_UP_T;
				3'd1:    c = CH_LOW_R;
				3'd2:    c = CH_LOW_U;
				3'd3:    c = CH_LOW_E;
				default: c = 8'h00;
			endcase
		end
		return c;
	endfunction

endpackage

FILE: hdl/ftc_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftc_lexer
// next recognizer state for one character and the type of the field so far
// ----------------------------------------------------------------------------
module ftc_lexer (
	input  ftc_pkg::lex_t        cur,
	input  logic [7:0]           ch,
	output ftc_pkg::lex_t        nxt,
	output ftc_pkg::field_type_t kind
);
	import ftc_pkg::*;

	always_comb begin
		nxt = cur;
		unique case (cur.state)
			ST_START: begin
				if (is_sgn(ch)) begin
					nxt.saw_sign = 1'b1;
					nxt.state    = ST_SIGN;
				end else if (is_dig(ch)) begin
					nxt.saw_digit = 1'b1;
					nxt.state     = ST_INT;
				end else if (ch == CH_POINT) begin
					nxt.state = ST_POINT;
				end else if (ch == CH_UP_T) begin
					nxt.pos      = 3'd1;
					nxt.is_false = 1'b0;
					nxt.state    = ST_WORD;
				end else if (ch == CH_UP_F) begin
					nxt.pos      = 3'd1;
					nxt.is_false = 1'b1;
					nxt.state    = ST_WORD;
				end else begin
					nxt.state = ST_STR;
				end
			end
			ST_SIGN: begin
				if (is_dig(ch)) begin
					nxt.saw_digit = 1'b1;
					nxt.state     = ST_INT;
				end else if (ch == CH_POINT) begin
					nxt.state = ST_POINT;
				end else begin
					nxt.state = ST_STR;
				end
			end
			ST_INT: begin
				if (is_dig(ch)) begin
					nxt.state = ST_INT;
				end else if (ch == CH_POINT) begin
					nxt.state = ST_POINT;
				end else if (is_exp(ch)) begin
					nxt.state = ST_EXPE;
				end else begin
					nxt.state = ST_STR;
				end
			end
			ST_POINT: begin
				if (is_dig(ch)) begin
					nxt.saw_digit = 1'b1;
					nxt.state     = ST_FRAC;
				end else if (is_exp(ch)) begin
					nxt.state = ST_EXPE;
				end else begin
					nxt.state = ST_STR;
				end
			end
			ST_FRAC: begin
				if (is_dig(ch)) begin
					nxt.state = ST_FRAC;
				end else if (is_exp(ch)) begin
					nxt.state = ST_EXPE;
				end else begin
					nxt.state = ST_STR;
				end
			end
			ST_EXPE: begin
				if (is_sgn(ch)) begin
					nxt.state = ST_EXPSIGN;
				end else if (is_dig(ch)) begin
					nxt.state = ST_EXP;
				end else begin
					nxt.state = ST_STR;
				end
			end
			ST_EXPSIGN: begin
				nxt.state = is_dig(ch) ? ST_EXP : ST_STR;
			end
			ST_EXP: begin
				nxt.state = is_dig(ch) ? ST_EXP : ST_STR;
			end
			ST_WORD: begin
				if ((cur.pos < word_len(cur.is_false))
						&& (ch == word_char(cur.is_false, cur.pos))) begin
					nxt.pos = cur.pos + 3'd1;
				end else begin
					nxt.state = ST_STR;
				end
			end
			default: begin
				nxt.state = ST_STR;
			end
		endcase
	end

	always_comb begin
		unique case (cur.state)
			ST_START: kind = TYPE_EMPTY;
			ST_SIGN:  kind = TYPE_STR;
			ST_INT:   kind = cur.saw_sign ? TYPE_SINT : TYPE_UINT;
			ST_FRAC:  kind = TYPE_FLOAT;
			ST_POINT, ST_EXPE, ST_EXPSIGN, ST_EXP: begin
				// a point or exponent mark with no digits after it still counts as float if a mantissa digit was seen
				kind = cur.saw_digit ? TYPE_FLOAT : TYPE_STR;
			end
			ST_WORD:  kind = (cur.pos == word_len(cur.is_false)) ? TYPE_BOOL : TYPE_STR;
			default:  kind = TYPE_STR;
		endcase
	end

endmodule

FILE: hdl/field_type_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// field_type_classifier
// classifies a text field fed one character per transfer
// ----------------------------------------------------------------------------
// input channel: in_valid / in_ready carry ch and field_end. one transfer per
// character; a transfer with field_end high closes the field and its ch is
// ignored.
// output channel: out_valid / out_ready carry field_type, one result per
// closed field: 0 empty, 1 unsigned int, 2 signed int, 3 float, 4 bool,
// 5 string.
// every accepted item lands in an input register; when it moves on, the
// recognizer state is updated from it and, for an end marker, the type is
// loaded into the output register. throughput is one item per cycle unless
// an end marker waits, set by the single recognizer update between the two
// registers. a character item never waits on the output side; an end
// marker waits in the input register while an earlier result is still
// held, and in_ready stays high as long as that register can drain.
// reset empties both registers and returns the recognizer to its start state.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module field_type_classifier (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           ch,
	input  logic                 field_end,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ftc_pkg::field_type_t field_type
);
	import ftc_pkg::*;

	logic        valid_s1;
	logic [7:0]  ch_s1;
	logic        end_s1;
	logic        adv_s1;
	logic        close_s1;
	lex_t        lex_q;
	lex_t        lex_nxt;
	field_type_t kind;
	logic        out_valid_q;
	field_type_t field_type_q;

	// an end marker only moves on when the output register is free
	assign adv_s1   = valid_s1 && (!end_s1 || !out_valid_q || out_ready);
	assign close_s1 = adv_s1 && end_s1;
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ch_s1  <= ch;
			end_s1 <= field_end;
		end
	end

	ftc_lexer u_lexer (
		.cur  (lex_q),
		.ch   (ch_s1),
		.nxt  (lex_nxt),
		.kind (kind)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lex_q <= LEX_RESET;
		end else if (close_s1) begin
			lex_q <= LEX_RESET;
		end else if (adv_s1) begin
			lex_q <= lex_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (close_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (close_s1) begin
			field_type_q <= kind;
		end
	end

	assign out_valid  = out_valid_q;
	assign field_type = field_type_q;

	`FTC_ASSERT(a_close_restarts, close_s1 |=> (lex_q == LEX_RESET))
	`FTC_ASSERT_NEVER(a_no_result_overwrite, close_s1 && out_valid_q && !out_ready)
	`FTC_ASSERT(a_word_pos_range, (lex_q.state == ST_WORD) |-> (lex_q.pos != 3'd0 && lex_q.pos <= word_len(lex_q.is_false)))
	`FTC_ASSERT(a_int_has_digit, (lex_q.state == ST_INT) |-> lex_q.saw_digit)

endmodule
